[src/ecpa_pkg.sv]
// Package with the transaction types, constants and modular helpers of the point unit.
`timescale 1ns / 1ps

package ecpa_pkg;

  // Field and scalar widths are fixed by the transaction formats.
  localparam int FIELD_BITS  = 16;
  localparam int SCALAR_BITS = 16;
  localparam int BIT_IDX_BITS = $clog2(SCALAR_BITS);
  localparam int SHIFT_BITS  = $clog2(FIELD_BITS);
  // Bezout coefficients stay within the modulus in magnitude, plus a sign.
  localparam int S_BITS  = FIELD_BITS + 2;
  localparam int TS_BITS = S_BITS + FIELD_BITS;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CURVE_A     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FIELD_PRIME = 2'd1;

  // Operation codes.
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_MULT = 1'b1;

  // Register values after reset, and the smallest modulus used.
  localparam logic [FIELD_BITS-1:0] CURVE_A_RESET     = 16'd1;
  localparam logic [FIELD_BITS-1:0] FIELD_PRIME_RESET = 16'd23;
  localparam logic [FIELD_BITS-1:0] MIN_PRIME         = 16'd3;

  typedef logic [FIELD_BITS-1:0] field_t;

  typedef struct packed {
    logic                   operation;
    field_t                 first_x;
    field_t                 first_y;
    logic                   first_inf;
    field_t                 second_x;
    field_t                 second_y;
    logic                   second_inf;
    logic [SCALAR_BITS-1:0] scalar;
  } req_t;

  typedef struct packed {
    field_t result_x;
    field_t result_y;
    logic   result_inf;
  } rsp_t;

  // Sum of two residues, reduced once.
  function automatic field_t mod_add(field_t a, field_t b, field_t m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[FIELD_BITS-1:0];
  endfunction

  // Difference of two residues, brought back into range.
  function automatic field_t mod_sub(field_t a, field_t b, field_t m);
    logic [FIELD_BITS:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      s = s + {1'b0, m};
    end
    return s[FIELD_BITS-1:0];
  endfunction

endpackage

[src/ec_point_add_scalar_mult_top.sv]
// Elliptic-curve point addition and scalar multiplication over GF(p), with a small sequencer.
// A reduction pass over the operands comes first; each point addition is then bounded by the
//   Euclidean inverse (a shift-and-subtract divider) and three 16-step
//   bit-serial modular multiplications, four for a doubling; an infinity operand ends at once.
// Scalar multiply runs up to 2 x SCALAR_BITS point operations.
// Throughput: one transaction at a time; the next is taken once the result is registered.
// Reset: synchronous; curve_a returns to 1, field_prime to 23, and the sequencer to idle.
`timescale 1ns / 1ps

module ec_point_add_scalar_mult_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_ready,
  input  ecpa_pkg::req_t                        req,
  output logic                                  rsp_valid,
  input  logic                                  rsp_ready,
  output ecpa_pkg::rsp_t                        rsp,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ecpa_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  ecpa_pkg::field_t                      cfg_data
);

  localparam int FB = ecpa_pkg::FIELD_BITS;
  localparam int SB = ecpa_pkg::S_BITS;
  localparam int TB = ecpa_pkg::TS_BITS;

  // Sequencer codes.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RED_LOAD = 5'd1;
  localparam logic [4:0] S_RED_STORE = 5'd2;
  localparam logic [4:0] S_OPSTART  = 5'd3;
  localparam logic [4:0] S_SM_DBL   = 5'd4;
  localparam logic [4:0] S_SM_BIT   = 5'd5;
  localparam logic [4:0] S_SM_NEXT  = 5'd6;
  localparam logic [4:0] S_FIN      = 5'd7;
  localparam logic [4:0] S_P_START  = 5'd8;
  localparam logic [4:0] S_P_DBL1   = 5'd9;
  localparam logic [4:0] S_P_DBL2   = 5'd10;
  localparam logic [4:0] S_P_DBL3   = 5'd11;
  localparam logic [4:0] S_P_INV    = 5'd12;
  localparam logic [4:0] S_I_LOOP   = 5'd13;
  localparam logic [4:0] S_I_SWAP   = 5'd14;
  localparam logic [4:0] S_P_LAM    = 5'd15;
  localparam logic [4:0] S_P_X1     = 5'd16;
  localparam logic [4:0] S_P_X2     = 5'd17;
  localparam logic [4:0] S_P_X3     = 5'd18;
  localparam logic [4:0] S_P_Y1     = 5'd19;
  localparam logic [4:0] S_D_ALIGN  = 5'd20;
  localparam logic [4:0] S_D_SUB    = 5'd21;
  localparam logic [4:0] S_MUL      = 5'd22;

  // Values loaded for reduction, in order: a, first x, first y, second x, second y.
  localparam logic [2:0] RED_LAST = 3'd4;
  localparam logic [ecpa_pkg::SHIFT_BITS-1:0] MUL_TOP =
    ecpa_pkg::SHIFT_BITS'(FB - 1);
  localparam logic [ecpa_pkg::SHIFT_BITS-1:0] SH_ONE = ecpa_pkg::SHIFT_BITS'(1);
  localparam logic [ecpa_pkg::BIT_IDX_BITS-1:0] BIT_ONE = ecpa_pkg::BIT_IDX_BITS'(1);

  logic [4:0] state;
  logic [4:0] ret;
  logic [4:0] pret;

  ecpa_pkg::field_t curve_a;
  ecpa_pkg::field_t field_prime;
  ecpa_pkg::field_t m;
  ecpa_pkg::field_t ared;

  logic                            op;
  logic [ecpa_pkg::SCALAR_BITS-1:0] k;
  logic [ecpa_pkg::BIT_IDX_BITS-1:0] bit_idx;
  logic [2:0]                      red_idx;

  // Operands held for the whole transaction.
  ecpa_pkg::field_t ax, ay, bx, by;
  logic             ainf, binf;

  // Point-add operands and running result.
  ecpa_pkg::field_t px, py, qx, qy, rx, ry, x3;
  logic             pinf, qinf, rinf;
  ecpa_pkg::field_t num, den;

  // Shared divider and Euclid registers.
  ecpa_pkg::field_t                r0, r1, tr;
  logic signed [SB-1:0]            s0, s1;
  logic signed [TB-1:0]            ts;
  logic [ecpa_pkg::SHIFT_BITS-1:0] sh;

  // Shared bit-serial modular multiplier.
  ecpa_pkg::field_t                ma, mb, mr;
  logic [ecpa_pkg::SHIFT_BITS-1:0] mc;

  ecpa_pkg::field_t red_src;
  ecpa_pkg::field_t inv_val;
  ecpa_pkg::field_t mul_next;
  ecpa_pkg::field_t dbl_tmp;

  assign req_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Value that the reduction pass is working on.
  always_comb begin
    case (red_idx)
      3'd0:    red_src = ared;
      3'd1:    red_src = ax;
      3'd2:    red_src = ay;
      3'd3:    red_src = bx;
      default: red_src = by;
    endcase
  end

  // Inverse at the end of Euclid: the coefficient brought into range, or 0 without one.
  always_comb begin
    if (r0 == ecpa_pkg::field_t'(1)) begin
      if (s0[SB-1]) begin
        inv_val = s0[FB-1:0] + m;
      end else begin
        inv_val = s0[FB-1:0];
      end
    end else begin
      inv_val = '0;
    end
  end

  // One step of the multiplier: double, then add the multiplicand when the bit is set.
  always_comb begin
    dbl_tmp = ecpa_pkg::mod_add(mr, mr, m);
    if (ma[mc]) begin
      mul_next = ecpa_pkg::mod_add(dbl_tmp, mb, m);
    end else begin
      mul_next = dbl_tmp;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      curve_a     <= ecpa_pkg::CURVE_A_RESET;
      field_prime <= ecpa_pkg::FIELD_PRIME_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ecpa_pkg::REG_CURVE_A:     curve_a     <= cfg_data;
        ecpa_pkg::REG_FIELD_PRIME: field_prime <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // The finishing state drives the output valid itself.
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op      <= req.operation;
            k       <= req.scalar;
            ared    <= curve_a;
            ax      <= req.first_x;
            ay      <= req.first_y;
            ainf    <= req.first_inf;
            bx      <= req.second_x;
            by      <= req.second_y;
            binf    <= req.second_inf;
            m       <= (field_prime < ecpa_pkg::MIN_PRIME) ? ecpa_pkg::MIN_PRIME : field_prime;
            red_idx <= '0;
            state   <= S_RED_LOAD;
          end
        end
        S_RED_LOAD: begin
          r0    <= red_src;
          r1    <= m;
          tr    <= m;
          ts    <= '0;
          sh    <= '0;
          ret   <= S_RED_STORE;
          state <= S_D_ALIGN;
        end
        S_RED_STORE: begin
          case (red_idx)
            3'd0:    ared <= r0;
            3'd1:    ax   <= r0;
            3'd2:    ay   <= r0;
            3'd3:    bx   <= r0;
            default: by   <= r0;
          endcase
          if (red_idx == RED_LAST) begin
            state <= S_OPSTART;
          end else begin
            red_idx <= red_idx + 3'd1;
            state   <= S_RED_LOAD;
          end
        end
        S_OPSTART: begin
          if (op == ecpa_pkg::OP_ADD) begin
            px    <= ax;
            py    <= ay;
            pinf  <= ainf;
            qx    <= bx;
            qy    <= by;
            qinf  <= binf;
            pret  <= S_FIN;
            state <= S_P_START;
          end else begin
            rx      <= '0;
            ry      <= '0;
            rinf    <= 1'b1;
            bit_idx <= ecpa_pkg::BIT_IDX_BITS'(ecpa_pkg::SCALAR_BITS - 1);
            state   <= S_SM_DBL;
          end
        end
        S_SM_DBL: begin
          px    <= rx;
          py    <= ry;
          pinf  <= rinf;
          qx    <= rx;
          qy    <= ry;
          qinf  <= rinf;
          pret  <= S_SM_BIT;
          state <= S_P_START;
        end
        S_SM_BIT: begin
          if (k[bit_idx]) begin
            px    <= rx;
            py    <= ry;
            pinf  <= rinf;
            qx    <= ax;
            qy    <= ay;
            qinf  <= ainf;
            pret  <= S_SM_NEXT;
            state <= S_P_START;
          end else begin
            state <= S_SM_NEXT;
          end
        end
        S_SM_NEXT: begin
          if (bit_idx == '0) begin
            state <= S_FIN;
          end else begin
            bit_idx <= bit_idx - BIT_ONE;
            state   <= S_SM_DBL;
          end
        end
        S_FIN: begin
          // The previous result must have left the output register first.
          if (!rsp_valid || rsp_ready) begin
            rsp_valid      <= 1'b1;
            rsp.result_x   <= rinf ? '0 : rx;
            rsp.result_y   <= rinf ? '0 : ry;
            rsp.result_inf <= rinf;
            state          <= S_IDLE;
          end
        end
        S_P_START: begin
          if (pinf) begin
            rx    <= qx;
            ry    <= qy;
            rinf  <= qinf;
            state <= pret;
          end else if (qinf) begin
            rx    <= px;
            ry    <= py;
            rinf  <= 1'b0;
            state <= pret;
          end else if (px == qx) begin
            if (py != qy || py == '0) begin
              rx    <= '0;
              ry    <= '0;
              rinf  <= 1'b1;
              state <= pret;
            end else begin
              ma    <= px;
              mb    <= px;
              mr    <= '0;
              mc    <= MUL_TOP;
              ret   <= S_P_DBL1;
              state <= S_MUL;
            end
          end else begin
            num   <= ecpa_pkg::mod_sub(qy, py, m);
            den   <= ecpa_pkg::mod_sub(qx, px, m);
            state <= S_P_INV;
          end
        end
        // Tangent numerator 3x^2 + a, built by repeated modular addition.
        S_P_DBL1: begin
          num   <= ecpa_pkg::mod_add(mr, mr, m);
          state <= S_P_DBL2;
        end
        S_P_DBL2: begin
          num   <= ecpa_pkg::mod_add(num, mr, m);
          state <= S_P_DBL3;
        end
        S_P_DBL3: begin
          num   <= ecpa_pkg::mod_add(num, ared, m);
          den   <= ecpa_pkg::mod_add(py, py, m);
          state <= S_P_INV;
        end
        S_P_INV: begin
          r0    <= m;
          r1    <= den;
          s0    <= '0;
          s1    <= SB'(1);
          state <= S_I_LOOP;
        end
        S_I_LOOP: begin
          if (r1 == '0) begin
            ma    <= num;
            mb    <= inv_val;
            mr    <= '0;
            mc    <= MUL_TOP;
            ret   <= S_P_LAM;
            state <= S_MUL;
          end else begin
            tr    <= r1;
            ts    <= TB'(s1);
            sh    <= '0;
            ret   <= S_I_SWAP;
            state <= S_D_ALIGN;
          end
        end
        S_I_SWAP: begin
          r0    <= r1;
          r1    <= r0;
          s0    <= s1;
          s1    <= s0;
          state <= S_I_LOOP;
        end
        S_P_LAM: begin
          ma    <= mr;
          mb    <= mr;
          mr    <= '0;
          mc    <= MUL_TOP;
          ret   <= S_P_X1;
          state <= S_MUL;
        end
        S_P_X1: begin
          x3    <= ecpa_pkg::mod_sub(mr, px, m);
          state <= S_P_X2;
        end
        S_P_X2: begin
          x3    <= ecpa_pkg::mod_sub(x3, qx, m);
          state <= S_P_X3;
        end
        S_P_X3: begin
          // The multiplier still holds the slope in ma.
          mb    <= ecpa_pkg::mod_sub(px, x3, m);
          mr    <= '0;
          mc    <= MUL_TOP;
          ret   <= S_P_Y1;
          state <= S_MUL;
        end
        S_P_Y1: begin
          rx    <= x3;
          ry    <= ecpa_pkg::mod_sub(mr, py, m);
          rinf  <= 1'b0;
          state <= pret;
        end
        // Divider: shift the divisor up to the dividend, then subtract on the way down.
        S_D_ALIGN: begin
          if ({tr, 1'b0} <= {1'b0, r0}) begin
            tr <= {tr[FB-2:0], 1'b0};
            ts <= ts <<< 1;
            sh <= sh + SH_ONE;
          end else begin
            state <= S_D_SUB;
          end
        end
        S_D_SUB: begin
          if (r0 >= tr) begin
            r0 <= r0 - tr;
            s0 <= s0 - ts[SB-1:0];
          end
          if (sh == '0) begin
            state <= ret;
          end else begin
            tr <= tr >> 1;
            ts <= ts >>> 1;
            sh <= sh - SH_ONE;
          end
        end
        S_MUL: begin
          mr <= mul_next;
          if (mc == '0) begin
            state <= ret;
          end else begin
            mc <= mc - SH_ONE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // An accepted transaction always starts with the reduction pass.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_RED_LOAD))
    else $error("transaction did not start reduction");

  // The working modulus is never below the minimum while busy.
  a_modulus: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && !$past(state == S_IDLE)) |-> (m >= ecpa_pkg::MIN_PRIME))
    else $error("working modulus below minimum");

  // The divider never aligns a zero divisor.
  a_divisor: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_ALIGN) |-> (tr != '0))
    else $error("zero divisor in divider");

  // A finite result is fully reduced when it is handed out.
  a_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && !rinf) |-> (rx < m && ry < m))
    else $error("result coordinate not reduced");

endmodule

[sim/ec_point_add_scalar_mult_top_tb.sv]
// Self-checking testbench for the elliptic-curve point addition and scalar multiply unit.
`timescale 1ns / 1ps

module ec_point_add_scalar_mult_top_tb;

  localparam longint CYCLE_LIMIT = 20_000_000;

  typedef logic [ecpa_pkg::SCALAR_BITS-1:0] scalar_t;

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    bit              inf;
  } ec_point_t;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  ecpa_pkg::req_t    req;
  logic              rsp_valid;
  logic              rsp_ready;
  ecpa_pkg::rsp_t    rsp;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ecpa_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  ecpa_pkg::field_t  cfg_data;

  // Local copy of the curve registers and the queue of predicted points.
  ecpa_pkg::field_t  shadow_curve_a;
  ecpa_pkg::field_t  shadow_prime;
  ecpa_pkg::rsp_t    expected_points[$];
  int                mismatches = 0;
  longint            cycle_count = 0;
  bit                quiet_mode;
  int                stall_left = 0;

  ec_point_add_scalar_mult_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Modular inverse by the extended Euclidean algorithm; no inverse gives 0.
  function automatic longint unsigned inv_mod(longint unsigned v, longint unsigned m);
    longint r0, r1, s0, s1, q, rt, st;
    r0 = m;
    r1 = v % m;
    s0 = 0;
    s1 = 1;
    while (r1 != 0) begin
      q  = r0 / r1;
      rt = r0 - q * r1;
      st = s0 - q * s1;
      r0 = r1;
      r1 = rt;
      s0 = s1;
      s1 = st;
    end
    if (r0 != 1) begin
      return 0;
    end
    s0 = s0 % longint'(m);
    if (s0 < 0) begin
      s0 = s0 + longint'(m);
    end
    return longint'(s0);
  endfunction

  // Affine point sum, with infinity as the identity.
  function automatic ec_point_t add_points(ec_point_t p, ec_point_t q,
                                           longint unsigned a, longint unsigned m);
    ec_point_t r;
    longint unsigned slope, num, den;
    r.x = 0;
    r.y = 0;
    r.inf = 1'b1;
    if (p.inf) begin
      return q;
    end
    if (q.inf) begin
      return p;
    end
    if (p.x == q.x) begin
      if (p.y != q.y || p.y == 0) begin
        return r;
      end
      slope = (3 * ((p.x * p.x) % m) + a) % m;
      slope = (slope * inv_mod((2 * p.y) % m, m)) % m;
    end else begin
      num   = (q.y + m - p.y) % m;
      den   = (q.x + m - p.x) % m;
      slope = (num * inv_mod(den, m)) % m;
    end
    r.x = ((slope * slope) % m + 2 * m - p.x - q.x) % m;
    r.y = ((slope * ((p.x + m - r.x) % m)) % m + m - p.y) % m;
    r.inf = 1'b0;
    return r;
  endfunction

  // Expected result point of one request under the current register values.
  function automatic ecpa_pkg::rsp_t predict_point(ecpa_pkg::req_t item);
    longint unsigned m, a;
    ec_point_t p1, p2, r;
    ecpa_pkg::rsp_t out;
    m = (shadow_prime < ecpa_pkg::MIN_PRIME) ? ecpa_pkg::MIN_PRIME : shadow_prime;
    a = shadow_curve_a % m;
    p1.x = item.first_x % m;
    p1.y = item.first_y % m;
    p1.inf = item.first_inf;
    p2.x = item.second_x % m;
    p2.y = item.second_y % m;
    p2.inf = item.second_inf;
    if (item.operation == ecpa_pkg::OP_ADD) begin
      r = add_points(p1, p2, a, m);
    end else begin
      r.x = 0;
      r.y = 0;
      r.inf = 1'b1;
      for (int i = ecpa_pkg::SCALAR_BITS - 1; i >= 0; i--) begin
        r = add_points(r, r, a, m);
        if (item.scalar[i]) begin
          r = add_points(r, p1, a, m);
        end
      end
    end
    if (r.inf) begin
      r.x = 0;
      r.y = 0;
    end
    out.result_x   = r.x[ecpa_pkg::FIELD_BITS-1:0];
    out.result_y   = r.y[ecpa_pkg::FIELD_BITS-1:0];
    out.result_inf = r.inf;
    return out;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 20);
    end
    return $urandom_range(50, 200);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Sends one request transaction and records its predicted result.
  task automatic send_request(ecpa_pkg::req_t item);
    int gap;
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
    expected_points.push_back(predict_point(item));
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits until every predicted result has arrived, then a short settling pause.
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes one configuration register while the unit is idle.
  task automatic write_reg(logic [ecpa_pkg::CFG_INDEX_BITS-1:0] idx, ecpa_pkg::field_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ecpa_pkg::REG_CURVE_A) begin
      shadow_curve_a = value;
    end else if (idx == ecpa_pkg::REG_FIELD_PRIME) begin
      shadow_prime = value;
    end
    @(posedge clk);
  endtask

  function automatic ecpa_pkg::req_t make_req(logic op, ecpa_pkg::field_t fx,
                                              ecpa_pkg::field_t fy, logic fi,
                                              ecpa_pkg::field_t sx, ecpa_pkg::field_t sy,
                                              logic si, scalar_t k);
    ecpa_pkg::req_t item;
    item.operation  = op;
    item.first_x    = fx;
    item.first_y    = fy;
    item.first_inf  = fi;
    item.second_x   = sx;
    item.second_y   = sy;
    item.second_inf = si;
    item.scalar     = k;
    return item;
  endfunction

  // Random coordinate: mostly a residue, sometimes any 16-bit value.
  function automatic ecpa_pkg::field_t rand_coord();
    longint unsigned m;
    m = (shadow_prime < ecpa_pkg::MIN_PRIME) ? ecpa_pkg::MIN_PRIME : shadow_prime;
    if ($urandom_range(0, 9) == 0) begin
      return ecpa_pkg::field_t'($urandom);
    end
    return ecpa_pkg::field_t'($urandom_range(0, int'(m) - 1));
  endfunction

  // Random request, biased towards doublings and opposite points.
  function automatic ecpa_pkg::req_t rand_request();
    ecpa_pkg::req_t item;
    longint unsigned m;
    int shape;
    m = (shadow_prime < ecpa_pkg::MIN_PRIME) ? ecpa_pkg::MIN_PRIME : shadow_prime;
    item.operation  = ($urandom_range(0, 99) < 35) ? ecpa_pkg::OP_MULT : ecpa_pkg::OP_ADD;
    item.first_x    = rand_coord();
    item.first_y    = rand_coord();
    item.first_inf  = ($urandom_range(0, 15) == 0);
    item.second_x   = rand_coord();
    item.second_y   = rand_coord();
    item.second_inf = ($urandom_range(0, 15) == 0);
    item.scalar     = scalar_t'($urandom);
    shape = $urandom_range(0, 9);
    if (shape < 2) begin
      item.second_x = item.first_x;
      item.second_y = item.first_y;
    end else if (shape < 4) begin
      item.second_x = item.first_x;
      item.second_y = ecpa_pkg::field_t'((m - (item.first_y % m)) % m);
    end else if (shape == 4) begin
      item.scalar = scalar_t'($urandom_range(0, 3));
    end
    return item;
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) begin
      send_request(rand_request());
    end
  endtask

  // Directed cases on the reset curve y^2 = x^3 + x + 1 over GF(23).
  task automatic test_directed();
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd3, 16'd10, 1'b0, 16'd9, 16'd7, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd3, 16'd10, 1'b0, 16'd3, 16'd10, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd3, 16'd10, 1'b0, 16'd3, 16'd13, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd5, 16'd0, 1'b0, 16'd5, 16'd0, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 16'd9, 16'd7, 1'b0,
                          16'hFFFF));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd3, 16'd10, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1,
                          16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0, 1'b1, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0,
                          16'hFFFF));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd26, 16'd33, 1'b0, 16'd3, 16'd10, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_ADD, 16'd0, 16'd1, 1'b0, 16'd0, 16'd22, 1'b0, 16'd0));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd3, 16'd10, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1,
                          16'd0));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd3, 16'd10, 1'b0, 16'd0, 16'd0, 1'b0, 16'd1));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd3, 16'd10, 1'b0, 16'd9, 16'd7, 1'b0, 16'd2));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd3, 16'd10, 1'b0, 16'd0, 16'd0, 1'b0,
                          16'hFFFF));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd3, 16'd10, 1'b1, 16'd0, 16'd0, 1'b0, 16'd77));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0, 1'b0,
                          16'h8000));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd5, 16'd0, 1'b0, 16'd0, 16'd0, 1'b0, 16'd3));
    send_request(make_req(ecpa_pkg::OP_MULT, 16'd9, 16'd7, 1'b0, 16'd0, 16'd0, 1'b0, 16'd28));
    drain_results();
  endtask

  // Random traffic on the reset curve, first with no idling, then with gaps.
  task automatic test_reset_curve_random();
    quiet_mode = 1'b1;
    send_random(30);
    quiet_mode = 1'b0;
    send_random(50);
    drain_results();
  endtask

  // Sweep of primes and curve coefficients, the extremes among them.
  task automatic test_prime_sweep();
    ecpa_pkg::field_t primes[6] = '{16'd3, 16'd5, 16'd97, 16'd251, 16'd40009, 16'd65521};
    ecpa_pkg::field_t coeffs[6] = '{16'd0, 16'd2, 16'd96, 16'hFFFF, 16'd12345, 16'd65520};
    for (int i = 0; i < 6; i++) begin
      write_reg(ecpa_pkg::REG_FIELD_PRIME, primes[i]);
      write_reg(ecpa_pkg::REG_CURVE_A, coeffs[i]);
      send_random(20);
      drain_results();
    end
  endtask

  // Moduli below three and moduli that are not prime.
  task automatic test_degenerate_moduli();
    ecpa_pkg::field_t moduli[6] = '{16'd0, 16'd1, 16'd2, 16'd15, 16'd1001, 16'hFFFF};
    for (int i = 0; i < 6; i++) begin
      write_reg(ecpa_pkg::REG_FIELD_PRIME, moduli[i]);
      write_reg(ecpa_pkg::REG_CURVE_A, ecpa_pkg::field_t'($urandom));
      send_random(15);
      drain_results();
    end
  endtask

  // Result stall pattern: bursts of readiness with short and occasional long stalls.
  always @(posedge clk) begin
    if (rst || quiet_mode) begin
      rsp_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 5) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 150)
                                                  : $urandom_range(1, 4);
      end
    end
  end

  // Compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    ecpa_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result, x", rsp.result_x, 0);
      end else begin
        want = expected_points.pop_front();
        if (rsp.result_x !== want.result_x) begin
          report_mismatch("result_x", rsp.result_x, want.result_x);
        end
        if (rsp.result_y !== want.result_y) begin
          report_mismatch("result_y", rsp.result_y, want.result_y);
        end
        if (rsp.result_inf !== want.result_inf) begin
          report_mismatch("result_inf", rsp.result_inf, want.result_inf);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst            <= 1'b1;
    req_valid      <= 1'b0;
    req            <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= ecpa_pkg::REG_CURVE_A;
    cfg_data       <= '0;
    quiet_mode     = 1'b0;
    shadow_curve_a = ecpa_pkg::CURVE_A_RESET;
    shadow_prime   = ecpa_pkg::FIELD_PRIME_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_reset_curve_random();
    test_prime_sweep();
    test_degenerate_moduli();

    if (expected_points.size() != 0) begin
      report_mismatch("results left over", expected_points.size(), 0);
    end
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/ecpa_pkg.sv
src/ec_point_add_scalar_mult_top.sv
sim/ec_point_add_scalar_mult_top_tb.sv
